// ===== hdl/bfx_pkg.sv =====
// shared types, instruction codes and limits for the instruction execute unit
package bfx_pkg;

    // instruction bytes
    localparam logic [7:0] CMD_INC   = 8'h2B;
    localparam logic [7:0] CMD_DEC   = 8'h2D;
    localparam logic [7:0] CMD_LEFT  = 8'h3C;
    localparam logic [7:0] CMD_RIGHT = 8'h3E;
    localparam logic [7:0] CMD_OUT   = 8'h2E;
    localparam logic [7:0] CMD_IN    = 8'h2C;
    localparam logic [7:0] CMD_OPEN  = 8'h5B;
    localparam logic [7:0] CMD_CLOSE = 8'h5D;

    localparam int PROGRAM_DEPTH = 4096;
    localparam logic [12:0] NEST_MAX  = 13'd8191;
    localparam logic [23:0] OPS_RESET = 24'd100000;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_OPLIMIT        = 3'd1,
        ST_UNDERFLOW      = 3'd2,
        ST_CLOSE_UNMATCHED = 3'd3,
        ST_OPEN_UNMATCHED = 3'd4,
        ST_TAPE_FULL      = 3'd5,
        ST_STACK_FULL     = 3'd6
    } status_t;

    // loop stack control from the executor
    typedef struct packed {
        logic        push;
        logic        pop;
        logic [11:0] pc;
    } stk_cmd_t;

    // loop stack state seen by the executor
    typedef struct packed {
        logic        empty;
        logic        full;
        logic [11:0] top;
    } stk_stat_t;

    // address after pc, capped at the program size
    function automatic logic [12:0] follow_pc(input logic [11:0] pc);
        logic [12:0] n;
        n = {1'b0, pc} + 13'd1;
        if (n > 13'(PROGRAM_DEPTH)) begin
            n = 13'(PROGRAM_DEPTH);
        end
        return n;
    endfunction

endpackage

// ===== hdl/bfx_loop_stack.sv =====
// loop address stack: entries in a memory, top of stack held in a register
module bfx_loop_stack #(
    parameter int LOOP_DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bfx_pkg::stk_cmd_t cmd,
    output bfx_pkg::stk_stat_t stat
);
    import bfx_pkg::*;

    localparam int AW = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
    localparam int CW = $clog2(LOOP_DEPTH + 1);

    logic [11:0]   stk_mem [LOOP_DEPTH];
    logic [CW-1:0] count_reg;
    logic [11:0]   top_reg;
    logic [11:0]   rd_q_reg;
    logic          sel_mem_reg;
    logic [CW-1:0] below_top;

    // entry under the current top, new top after a pop
    assign below_top = count_reg - CW'(2);

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stk_mem[count_reg[AW-1:0]] <= cmd.pc;
        end
        if (cmd.pop && count_reg >= CW'(2)) begin
            rd_q_reg <= stk_mem[below_top[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            sel_mem_reg <= 1'b0;
        end else if (cmd.push) begin
            count_reg   <= count_reg + CW'(1);
            sel_mem_reg <= 1'b0;
        end else if (cmd.pop) begin
            count_reg   <= count_reg - CW'(1);
            sel_mem_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            top_reg <= cmd.pc;
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg >= CW'(LOOP_DEPTH));
    assign stat.top   = sel_mem_reg ? rd_q_reg : top_reg;

    a_push_pop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.push && cmd.pop))
        else $error("push and pop in the same cycle");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(LOOP_DEPTH))
        else $error("loop stack count beyond depth");

    a_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> !stat.full)
        else $error("push into a full loop stack");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> !stat.empty)
        else $error("pop from an empty loop stack");

endmodule

// ===== hdl/bf_instruction_execute_unit.sv =====
// instruction execute unit: one tape machine instruction per request
// Executes one instruction per request on s_ and returns one result per request on m_.
// A request may be taken in every clock cycle: the current cell and the top of the loop
// stack live in registers, and after a pointer move the new cell comes from the tape
// memory's registered read port in the next cycle, so no stall is needed. The result
// register holds until taken and s_tready drops only while it is full and m_tready is
// low. The tape needs no clearing pass after reset: a cell right of the grow frontier
// has never been written and reads as zero when the pointer first steps onto it. An
// error is sticky until reset: every later request returns the error code with next_pc
// equal to pc and changes nothing. The operation limit is written on the cfg_ channel
// (always ready); the user must do so while the unit is idle, which is not enforced.
module bf_instruction_execute_unit #(
    parameter int TAPE_DEPTH = 4096,
    parameter int LOOP_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: operation limit
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    // instruction request
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // command[7:0], pc[19:8], in_byte[27:20], zero fill
    input  logic [0:0]  s_tuser,   // in_valid[0]
    input  logic        s_tlast,   // program_end
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // next_pc[12:0], out_byte[20:13], status[23:21]
    output logic [1:0]  m_tuser    // out_valid[0], input_taken[1]
);
    import bfx_pkg::*;

    localparam int AW = $clog2(TAPE_DEPTH);
    localparam int CW = $clog2(TAPE_DEPTH + 1);

    // request fields
    logic [7:0]  cmd;
    logic [11:0] pc_in;
    logic [7:0]  ib;
    logic        iv;
    logic        pend;
    logic        accept;

    assign cmd    = s_tdata[7:0];
    assign pc_in  = s_tdata[19:8];
    assign ib     = s_tdata[27:20];
    assign iv     = s_tuser[0];
    assign pend   = s_tlast;
    assign accept = s_tvalid && s_tready;

    // machine state
    logic [7:0]    tape_mem [TAPE_DEPTH];
    logic [7:0]    tape_q_reg;
    logic [7:0]    cell_reg;
    logic          cell_sel_mem_reg;   // current cell sits in tape_q_reg
    logic [AW-1:0] cp_reg;
    logic [CW-1:0] cells_reg;
    logic          skipping_reg;
    logic [12:0]   nest_reg;
    logic [23:0]   op_reg;
    status_t       err_reg;
    logic [23:0]   max_ops_reg;

    // result register
    logic          m_valid_reg;
    logic [23:0]   m_data_reg;
    logic [1:0]    m_user_reg;

    logic [7:0]    cur_cell;
    stk_cmd_t      stk_cmd;
    stk_stat_t     stk_stat;

    // next values
    logic [AW-1:0] cp_next;
    logic [CW-1:0] cells_next;
    logic          skipping_next;
    logic [12:0]   nest_next;
    logic [23:0]   op_next;
    status_t       err_next;
    logic          move;         // pointer moves, write back and fetch
    logic          grow;         // pointer steps onto a fresh zero cell
    logic          cell_wr;      // current cell takes cell_next
    logic [7:0]    cell_next;
    logic [12:0]   res_npc;
    logic [7:0]    res_ob;
    logic          res_ov;
    logic          res_taken;
    status_t       res_status;

    assign cur_cell = cell_sel_mem_reg ? tape_q_reg : cell_reg;

    always_comb begin
        cp_next       = cp_reg;
        cells_next    = cells_reg;
        skipping_next = skipping_reg;
        nest_next     = nest_reg;
        op_next       = op_reg;
        err_next      = err_reg;
        move          = 1'b0;
        grow          = 1'b0;
        cell_wr       = 1'b0;
        cell_next     = cur_cell;
        stk_cmd       = '0;
        stk_cmd.pc    = pc_in;
        res_npc       = follow_pc(pc_in);
        res_ob        = 8'd0;
        res_ov        = 1'b0;
        res_taken     = 1'b0;
        res_status    = ST_OK;

        if (err_reg != ST_OK) begin
            // sticky error, nothing moves
            res_npc    = {1'b0, pc_in};
            res_status = err_reg;
        end else if (pend) begin
            res_npc = {1'b0, pc_in};
            if (skipping_reg) begin
                err_next   = ST_OPEN_UNMATCHED;
                res_status = ST_OPEN_UNMATCHED;
            end
        end else if (skipping_reg) begin
            // forward skip to the matching close, not counted
            if (cmd == CMD_OPEN) begin
                if (nest_reg < NEST_MAX) begin
                    nest_next = nest_reg + 13'd1;
                end
            end else if (cmd == CMD_CLOSE) begin
                if (nest_reg == 13'd0) begin
                    skipping_next = 1'b0;
                end else begin
                    nest_next = nest_reg - 13'd1;
                end
            end
        end else if (op_reg >= max_ops_reg) begin
            err_next   = ST_OPLIMIT;
            res_npc    = {1'b0, pc_in};
            res_status = ST_OPLIMIT;
        end else begin
            op_next = op_reg + 24'd1;
            case (cmd)
                CMD_INC: begin
                    cell_wr   = 1'b1;
                    cell_next = cur_cell + 8'd1;
                end
                CMD_DEC: begin
                    cell_wr   = 1'b1;
                    cell_next = cur_cell - 8'd1;
                end
                CMD_LEFT: begin
                    if (cp_reg == '0) begin
                        err_next   = ST_UNDERFLOW;
                        res_npc    = {1'b0, pc_in};
                        res_status = ST_UNDERFLOW;
                    end else begin
                        move    = 1'b1;
                        cp_next = cp_reg - AW'(1);
                    end
                end
                CMD_RIGHT: begin
                    if (CW'(cp_reg) + CW'(1) >= cells_reg) begin
                        if (cells_reg >= CW'(TAPE_DEPTH)) begin
                            err_next   = ST_TAPE_FULL;
                            res_npc    = {1'b0, pc_in};
                            res_status = ST_TAPE_FULL;
                        end else begin
                            cells_next = cells_reg + CW'(1);
                            move       = 1'b1;
                            grow       = 1'b1;
                            cp_next    = cp_reg + AW'(1);
                        end
                    end else begin
                        move    = 1'b1;
                        cp_next = cp_reg + AW'(1);
                    end
                end
                CMD_OUT: begin
                    res_ob = cur_cell;
                    res_ov = 1'b1;
                end
                CMD_IN: begin
                    if (iv) begin
                        cell_wr   = 1'b1;
                        cell_next = ib;
                        res_taken = 1'b1;
                    end
                end
                CMD_OPEN: begin
                    if (cur_cell != 8'd0) begin
                        if (stk_stat.full) begin
                            err_next   = ST_STACK_FULL;
                            res_npc    = {1'b0, pc_in};
                            res_status = ST_STACK_FULL;
                        end else begin
                            stk_cmd.push = 1'b1;
                        end
                    end else begin
                        skipping_next = 1'b1;
                        nest_next     = 13'd0;
                    end
                end
                CMD_CLOSE: begin
                    if (stk_stat.empty) begin
                        err_next   = ST_CLOSE_UNMATCHED;
                        res_npc    = {1'b0, pc_in};
                        res_status = ST_CLOSE_UNMATCHED;
                    end else if (cur_cell != 8'd0) begin
                        res_npc = follow_pc(stk_stat.top);
                    end else begin
                        stk_cmd.pop = 1'b1;
                    end
                end
                default: begin
                    // other bytes only count
                end
            endcase
        end

        if (!accept) begin
            stk_cmd.push = 1'b0;
            stk_cmd.pop  = 1'b0;
        end
    end

    bfx_loop_stack #(
        .LOOP_DEPTH(LOOP_DEPTH)
    ) u_stack (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (stk_cmd),
        .stat   (stk_stat)
    );

    // tape memory: write back the old cell and fetch the new one on a move
    always_ff @(posedge aclk) begin
        if (accept && move) begin
            tape_mem[cp_reg] <= cur_cell;
            tape_q_reg       <= tape_mem[cp_next];
        end
    end

    // current cell register, cell zero starts cleared, fresh cells read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= 8'd0;
        end else if (accept && move && grow) begin
            cell_reg <= 8'd0;
        end else if (accept && cell_wr) begin
            cell_reg <= cell_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_sel_mem_reg <= 1'b0;
            cp_reg           <= '0;
            cells_reg        <= CW'(1);
            skipping_reg     <= 1'b0;
            nest_reg         <= 13'd0;
            op_reg           <= 24'd0;
            err_reg          <= ST_OK;
        end else if (accept) begin
            if (move) begin
                cell_sel_mem_reg <= !grow;
            end else if (cell_wr) begin
                cell_sel_mem_reg <= 1'b0;
            end
            cp_reg       <= cp_next;
            cells_reg    <= cells_next;
            skipping_reg <= skipping_next;
            nest_reg     <= nest_next;
            op_reg       <= op_next;
            err_reg      <= err_next;
        end
    end

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_ops_reg <= OPS_RESET;
        end else if (cfg_valid) begin
            max_ops_reg <= cfg_data;
        end
    end

    // result register
    assign s_tready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {res_status, res_ob, res_npc};
            m_user_reg <= {res_taken, res_ov};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg != ST_OK |=> err_reg == $past(err_reg))
        else $error("error code changed after being raised");

    a_cp_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(cp_reg) < cells_reg)
        else $error("cell pointer beyond cells in use");

    a_skip_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        skipping_reg |-> !stk_cmd.push && !stk_cmd.pop)
        else $error("loop stack touched while skipping");

    a_grow_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && grow |=> cur_cell == 8'd0)
        else $error("fresh cell not zero");

endmodule

// ===== bench/bf_instruction_execute_unit_tb.sv =====
// self-checking stream testbench for the tape machine instruction execute unit
`timescale 1ns / 1ps

module bf_instruction_execute_unit_tb;
    import bfx_pkg::*;

    localparam int TAPE_CELLS = 4096;
    localparam int LOOP_SLOTS = 64;
    localparam int CLK_PERIOD = 10;
    localparam int WATCHDOG_CYCLES = 3000;

    // one instruction request as the sender sees it
    typedef struct packed {
        logic [7:0]  command;
        logic [11:0] pc;
        logic [7:0]  in_byte;
        logic        in_valid;
        logic        program_end;
    } request_t;

    // one result as it leaves the unit
    typedef struct packed {
        logic [12:0] next_pc;
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        input_taken;
        status_t     status;
    } result_t;

    // directed stimulus row; known marks a result typed in by hand
    typedef struct packed {
        request_t req;
        logic     known;
        result_t  want;
    } plan_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    // machine state as the predictor keeps it
    logic [7:0]  tape_cells [TAPE_CELLS];
    logic [11:0] cell_ptr      = '0;
    logic [12:0] cells_used    = 13'd1;
    logic [11:0] loop_starts [LOOP_SLOTS];
    logic [6:0]  loop_depth    = '0;
    logic        skip_active   = 1'b0;
    logic [12:0] skip_depth    = '0;
    logic [23:0] ops_done      = '0;
    logic [23:0] op_limit      = OPS_RESET;
    status_t     sticky_status = ST_OK;

    result_t     pending_results[$];
    plan_row_t   directed_rows[$];
    logic [11:0] fetch_pc = '0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          requests_sent = 0;
    int          results_seen = 0;
    int          settings_written = 0;
    int          mismatches = 0;
    int          deepest = 0;
    int          quiet_cycles = 0;

    bf_instruction_execute_unit #(
        .TAPE_DEPTH(TAPE_CELLS),
        .LOOP_DEPTH(LOOP_SLOTS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // command[7:0], pc[19:8], in_byte[27:20], zero fill
        .s_tuser  (s_tuser),   // in_valid[0]
        .s_tlast  (s_tlast),   // program_end
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // next_pc[12:0], out_byte[20:13], status[23:21]
        .m_tuser  (m_tuser)    // out_valid[0], input_taken[1]
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // a 12-bit address plus one never passes the program size
    function automatic logic [12:0] next_addr(input logic [11:0] addr);
        return {1'b0, addr} + 13'd1;
    endfunction

    // executes one instruction on the predicted machine and returns its result
    function automatic result_t run_instruction(input request_t r);
        result_t res;
        logic    failed;
        failed = 1'b0;
        res = '0;
        res.next_pc = {1'b0, r.pc};
        res.status = ST_OK;
        // a raised error freezes everything until reset
        if (sticky_status != ST_OK) begin
            res.status = sticky_status;
            return res;
        end
        // end of code: only an open forward skip is wrong, open loops are fine
        if (r.program_end) begin
            if (skip_active) begin
                sticky_status = ST_OPEN_UNMATCHED;
                res.status = sticky_status;
            end
            return res;
        end
        // forward skip: only brackets matter, nothing is counted
        if (skip_active) begin
            if (r.command == CMD_OPEN) begin
                if (skip_depth != NEST_MAX) skip_depth = skip_depth + 13'd1;
            end else if (r.command == CMD_CLOSE) begin
                if (skip_depth == 0) skip_active = 1'b0;
                else skip_depth = skip_depth - 13'd1;
            end
            res.next_pc = next_addr(r.pc);
            return res;
        end
        // the limit check itself does not count the instruction
        if (ops_done >= op_limit) begin
            sticky_status = ST_OPLIMIT;
            res.status = sticky_status;
            return res;
        end
        ops_done = ops_done + 24'd1;
        res.next_pc = next_addr(r.pc);
        case (r.command)
            CMD_INC: tape_cells[cell_ptr] = tape_cells[cell_ptr] + 8'd1;
            CMD_DEC: tape_cells[cell_ptr] = tape_cells[cell_ptr] - 8'd1;
            CMD_LEFT: begin
                if (cell_ptr == 0) begin
                    sticky_status = ST_UNDERFLOW;
                    failed = 1'b1;
                end else begin
                    cell_ptr = cell_ptr - 12'd1;
                end
            end
            CMD_RIGHT: begin
                if ({1'b0, cell_ptr} + 13'd1 >= cells_used) begin
                    if (cells_used >= 13'(TAPE_CELLS)) begin
                        sticky_status = ST_TAPE_FULL;
                        failed = 1'b1;
                    end else begin
                        cells_used = cells_used + 13'd1;
                    end
                end
                if (!failed) cell_ptr = cell_ptr + 12'd1;
            end
            CMD_OUT: begin
                res.out_byte = tape_cells[cell_ptr];
                res.out_valid = 1'b1;
            end
            CMD_IN: begin
                // input exhausted leaves the cell alone
                if (r.in_valid) begin
                    tape_cells[cell_ptr] = r.in_byte;
                    res.input_taken = 1'b1;
                end
            end
            CMD_OPEN: begin
                if (tape_cells[cell_ptr] != 0) begin
                    if (loop_depth >= 7'(LOOP_SLOTS)) begin
                        sticky_status = ST_STACK_FULL;
                        failed = 1'b1;
                    end else begin
                        loop_starts[loop_depth] = r.pc;
                        loop_depth = loop_depth + 7'd1;
                    end
                end else begin
                    skip_active = 1'b1;
                    skip_depth = '0;
                end
            end
            CMD_CLOSE: begin
                if (loop_depth == 0) begin
                    sticky_status = ST_CLOSE_UNMATCHED;
                    failed = 1'b1;
                end else if (tape_cells[cell_ptr] != 0) begin
                    res.next_pc = next_addr(loop_starts[loop_depth - 7'd1]);
                end else begin
                    loop_depth = loop_depth - 7'd1;
                end
            end
            default: ;
        endcase
        if (failed) begin
            res.next_pc = {1'b0, r.pc};
            res.status = sticky_status;
        end
        return res;
    endfunction

    // a plain instruction at the current fetch address; fresh supplies the input byte
    function automatic request_t op(input logic [7:0] cmd, input logic [7:0] data = 8'h00,
                                    input logic fresh = 1'b0);
        request_t r;
        r.command = cmd;
        r.pc = fetch_pc;
        r.in_byte = fresh ? data : 8'($urandom);
        r.in_valid = fresh ? 1'b1 : 1'($urandom);
        r.program_end = 1'b0;
        return r;
    endfunction

    function automatic void plan(input logic [7:0] cmd, input logic [11:0] pc,
                                 input logic [7:0] data, input logic data_ok,
                                 input logic last, input logic known = 1'b0,
                                 input result_t want = '0);
        plan_row_t row;
        row.req = '{command: cmd, pc: pc, in_byte: data, in_valid: data_ok, program_end: last};
        row.known = known;
        row.want = want;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // sends one request, then books its expected result once it is taken
    task automatic issue(input request_t r, input logic known = 1'b0,
                         input result_t want = '0);
        result_t predicted;
        @(negedge aclk);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_tdata  <= {4'b0000, r.in_byte, r.pc, r.command};
        s_tuser  <= r.in_valid;
        s_tlast  <= r.program_end;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predicted = run_instruction(r);
        pending_results.insert(pending_results.size(), known ? want : predicted);
        fetch_pc = predicted.next_pc[11:0];
        requests_sent++;
        if (int'(loop_depth) > deepest) deepest = int'(loop_depth);
    endtask

    // new operation limit, written once the unit has drained
    task automatic set_limit(input logic [23:0] value);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        op_limit = value;
        settings_written++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side: random stall bursts, switched off by a zero percentage
    always begin
        @(negedge aclk);
        if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        m_tready <= 1'b1;
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("timeout: %0d cycles without a handshake, %0d results outstanding",
                     quiet_cycles, pending_results.size());
            $display("bf_instruction_execute_unit_tb failed");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.next_pc     = m_tdata[12:0];
            got.out_byte    = m_tdata[20:13];
            got.status      = status_t'(m_tdata[23:21]);
            got.out_valid   = m_tuser[0];
            got.input_taken = m_tuser[1];
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: tdata %h tuser %b",
                       m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.next_pc != want.next_pc) begin
                    $error("next_pc expected %0d got %0d", want.next_pc, got.next_pc);
                    mismatches++;
                end
                if (got.out_byte != want.out_byte) begin
                    $error("out_byte expected %h got %h", want.out_byte, got.out_byte);
                    mismatches++;
                end
                if (got.out_valid != want.out_valid) begin
                    $error("out_valid expected %b got %b", want.out_valid, got.out_valid);
                    mismatches++;
                end
                if (got.input_taken != want.input_taken) begin
                    $error("input_taken expected %b got %b",
                           want.input_taken, got.input_taken);
                    mismatches++;
                end
                if (got.status != want.status) begin
                    $error("status expected %0d got %0d", want.status, got.status);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        request_t r;
        status_t  err_pick;
        int       pick;
        logic     blocked;

        foreach (tape_cells[i]) tape_cells[i] = 8'h00;
        foreach (loop_starts[i]) loop_starts[i] = '0;

        // directed program: wraps, input edge cases, loops and nested skips
        plan(CMD_OUT,   12'd0,    8'h00, 1'b0, 1'b0, 1'b1, {13'd1,    8'h00, 1'b1, 1'b0, ST_OK});
        plan(CMD_IN,    12'd1,    8'h5A, 1'b0, 1'b0, 1'b1, {13'd2,    8'h00, 1'b0, 1'b0, ST_OK});
        plan(CMD_INC,   12'd4095, 8'h00, 1'b0, 1'b0, 1'b1, {13'd4096, 8'h00, 1'b0, 1'b0, ST_OK});
        plan(CMD_DEC,   12'd3,    8'h00, 1'b0, 1'b0, 1'b1, {13'd4,    8'h00, 1'b0, 1'b0, ST_OK});
        plan(CMD_DEC,   12'd4,    8'h00, 1'b0, 1'b0, 1'b1, {13'd5,    8'h00, 1'b0, 1'b0, ST_OK});
        plan(CMD_OUT,   12'd5,    8'h00, 1'b0, 1'b0, 1'b1, {13'd6,    8'hFF, 1'b1, 1'b0, ST_OK});
        plan(CMD_IN,    12'd6,    8'hFF, 1'b1, 1'b0, 1'b1, {13'd7,    8'h00, 1'b0, 1'b1, ST_OK});
        plan(CMD_RIGHT, 12'd7,    8'h00, 1'b0, 1'b0);
        plan(CMD_OUT,   12'd8,    8'h00, 1'b0, 1'b0, 1'b1, {13'd9,    8'h00, 1'b1, 1'b0, ST_OK});
        plan(CMD_LEFT,  12'd9,    8'h00, 1'b0, 1'b0);
        plan(CMD_OPEN,  12'd10,   8'h00, 1'b0, 1'b0);
        // taken close jumps back behind its open bracket
        plan(CMD_CLOSE, 12'd11,   8'h00, 1'b0, 1'b0, 1'b1, {13'd11,   8'h00, 1'b0, 1'b0, ST_OK});
        plan(CMD_IN,    12'd12,   8'h00, 1'b1, 1'b0, 1'b1, {13'd13,   8'h00, 1'b0, 1'b1, ST_OK});
        plan(CMD_CLOSE, 12'd13,   8'h00, 1'b0, 1'b0);
        // zero cell: skip forward over a nested pair and a stray move left
        plan(CMD_OPEN,  12'd14,   8'h00, 1'b0, 1'b0);
        plan(CMD_OPEN,  12'd15,   8'h00, 1'b0, 1'b0);
        plan(CMD_LEFT,  12'd16,   8'h00, 1'b0, 1'b0);
        plan(CMD_CLOSE, 12'd17,   8'h00, 1'b0, 1'b0);
        plan(8'h00,     12'd18,   8'h00, 1'b0, 1'b0);
        plan(CMD_CLOSE, 12'd19,   8'h00, 1'b0, 1'b0);
        plan(8'hFF,     12'd20,   8'h00, 1'b1, 1'b0);
        // program end ignores its command byte
        plan(CMD_INC,   12'd21,   8'h00, 1'b0, 1'b1, 1'b1, {13'd21,   8'h00, 1'b0, 1'b0, ST_OK});
        plan(CMD_OUT,   12'd0,    8'h00, 1'b0, 1'b0, 1'b1, {13'd1,    8'h00, 1'b1, 1'b0, ST_OK});
        plan(CMD_IN,    12'd23,   8'h80, 1'b1, 1'b0);
        plan(CMD_OPEN,  12'd24,   8'h00, 1'b0, 1'b0);
        // a loop left open at program end is fine
        plan(CMD_CLOSE, 12'd4095, 8'h00, 1'b0, 1'b1, 1'b1, {13'd4095, 8'h00, 1'b0, 1'b0, ST_OK});

        // synchronous reset, released on a falling clock edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        gap_pct = 20;
        stall_pct = 8;
        foreach (directed_rows[i]) begin
            issue(directed_rows[i].req, directed_rows[i].known, directed_rows[i].want);
        end
        set_limit(24'hFFFFFF);

        for (int seg = 0; seg < 8; seg++) begin
            if (seg == 2) begin
                // land exactly on the limit, then run skip content under a zero limit
                while (skip_active) issue(op(CMD_CLOSE));
                set_limit(ops_done + 24'd3);
                issue(op(CMD_IN, 8'h00, 1'b1));
                issue(op(CMD_OUT));
                issue(op(CMD_OPEN));
                issue(op(CMD_INC));
                issue(op(CMD_OPEN));
                issue(op(CMD_CLOSE));
                set_limit(24'd0);
                issue(op(CMD_LEFT));
                issue(op(CMD_CLOSE));
                r = op(CMD_DEC);
                r.program_end = 1'b1;
                issue(r);
                set_limit(24'hFFFFFF);
            end else if (seg == 4) begin
                // fill the loop stack to the last slot, then unwind it down to two entries
                while (skip_active) issue(op(CMD_CLOSE));
                issue(op(CMD_IN, 8'h01, 1'b1));
                while (loop_depth < 7'(LOOP_SLOTS)) issue(op(CMD_OPEN));
                issue(op(CMD_OUT));
                while (loop_depth > 7'd2) begin
                    issue(op(CMD_CLOSE));
                    issue(op(CMD_IN, 8'h00, 1'b1));
                    issue(op(CMD_CLOSE));
                    issue(op(CMD_INC));
                end
                set_limit(ops_done + 24'd1000 + 24'($urandom_range(0, 4000000)));
            end else if (seg == 6) begin
                set_limit(24'hFFFFFF);
            end else if (seg != 0) begin
                set_limit(ops_done + 24'd1000 + 24'($urandom_range(0, 4000000)));
            end

            // idle patterns differ per segment; the last segments run flat out
            gap_pct = (seg >= 6 || seg % 3 == 1) ? 0 : $urandom_range(5, 30);
            stall_pct = (seg >= 6 || seg % 3 == 2) ? 0 : $urandom_range(2, 12);

            repeat (190) begin
                r = op(CMD_INC);
                if ($urandom_range(0, 9) == 0) r.pc = 12'($urandom);
                r.in_byte = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
                r.in_valid = ($urandom_range(0, 4) != 0);
                pick = $urandom_range(0, 99);
                if (skip_active) begin
                    // skip content: mostly closing brackets, some nesting, some noise
                    if (pick < 35) r.command = CMD_CLOSE;
                    else if (pick < 50 && skip_depth < 13'd4) r.command = CMD_OPEN;
                    else r.command = 8'($urandom);
                end else begin
                    if (pick < 14) r.command = CMD_INC;
                    else if (pick < 22) r.command = CMD_DEC;
                    else if (pick < 32) r.command = CMD_LEFT;
                    else if (pick < 44) r.command = CMD_RIGHT;
                    else if (pick < 54) r.command = CMD_OUT;
                    else if (pick < 66) r.command = CMD_IN;
                    else if (pick < 78) r.command = CMD_OPEN;
                    else if (pick < 90) r.command = CMD_CLOSE;
                    else r.command = 8'($urandom);
                    r.program_end = (pick >= 96);
                    // keep the machine out of its error states here
                    blocked = (r.command == CMD_LEFT && cell_ptr == 0)
                           || (r.command == CMD_RIGHT && cell_ptr == 12'(TAPE_CELLS - 1))
                           || (r.command == CMD_OPEN && tape_cells[cell_ptr] != 0
                               && loop_depth >= 7'(LOOP_SLOTS))
                           || (r.command == CMD_CLOSE && loop_depth == 0);
                    if (blocked && !r.program_end) r.command = CMD_INC;
                end
                issue(r);
            end
        end

        // end on one error picked by the seed, then confirm that it sticks
        err_pick = status_t'($urandom_range(1, 6));
        while (skip_active) issue(op(CMD_CLOSE));
        case (err_pick)
            ST_OPLIMIT: begin
                set_limit(ops_done);
                issue(op(CMD_INC));
            end
            ST_UNDERFLOW: begin
                while (cell_ptr != 0) issue(op(CMD_LEFT));
                issue(op(CMD_LEFT));
            end
            ST_CLOSE_UNMATCHED: begin
                while (loop_depth != 0) begin
                    issue(op(CMD_IN, 8'h00, 1'b1));
                    issue(op(CMD_CLOSE));
                end
                issue(op(CMD_CLOSE));
            end
            ST_OPEN_UNMATCHED: begin
                issue(op(CMD_IN, 8'h00, 1'b1));
                issue(op(CMD_OPEN));
                r = op(CMD_OUT);
                r.program_end = 1'b1;
                issue(r);
            end
            ST_TAPE_FULL: begin
                // walk to the last cell; the step beyond it fails
                while (cell_ptr != 12'(TAPE_CELLS - 1)) issue(op(CMD_RIGHT));
                issue(op(CMD_RIGHT));
            end
            default: begin
                issue(op(CMD_IN, 8'h01, 1'b1));
                while (loop_depth < 7'(LOOP_SLOTS)) issue(op(CMD_OPEN));
                issue(op(CMD_OPEN));
            end
        endcase
        repeat (16) begin
            r.command = 8'($urandom);
            r.pc = 12'($urandom);
            r.in_byte = 8'($urandom);
            r.in_valid = 1'($urandom);
            r.program_end = ($urandom_range(0, 3) == 0);
            issue(r);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // catch any stray result after the last one
        repeat (8) @(posedge aclk);

        $display("ran %0d instructions with %0d results under %0d limit settings",
                 requests_sent, results_seen, settings_written);
        $display("loop stack reached %0d, tape grew to %0d cells, run closed on %s",
                 deepest, cells_used, sticky_status.name());
        if (mismatches == 0) begin
            $display("bf_instruction_execute_unit_tb passed");
        end else begin
            $display("bf_instruction_execute_unit_tb failed");
        end
        $finish;
    end

endmodule
